// ===== design/ps2h_pkg.sv =====
`default_nettype none
package ps2h_pkg;

	// request codes on the func field
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_CMD  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [1:0] CFG_BIT_SETUP = 2'd1;
	localparam logic [1:0] CFG_INHIBIT   = 2'd2;

	localparam logic [16:0] TIMEOUT_RESET   = 17'd100000;
	localparam logic [9:0]  BIT_SETUP_RESET = 10'd10;
	localparam logic [15:0] INHIBIT_RESET   = 16'd100;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_PARITY  = 2'd2
	} status_t;

	typedef enum logic [19:0] {
		PH_IDLE      = 20'b0000_0000_0000_0000_0001,
		PH_INHIBIT   = 20'b0000_0000_0000_0000_0010,
		PH_TX_REQ    = 20'b0000_0000_0000_0000_0100,
		PH_TX_SETUP  = 20'b0000_0000_0000_0000_1000,
		PH_TX_HIGH   = 20'b0000_0000_0000_0001_0000,
		PH_TX_LOW    = 20'b0000_0000_0000_0010_0000,
		PH_ACK_DATA  = 20'b0000_0000_0000_0100_0000,
		PH_ACK_CLK   = 20'b0000_0000_0000_1000_0000,
		PH_REL_DATA  = 20'b0000_0000_0001_0000_0000,
		PH_REL_CLK   = 20'b0000_0000_0010_0000_0000,
		PH_RS_DATA   = 20'b0000_0000_0100_0000_0000,
		PH_RS_CLKL   = 20'b0000_0000_1000_0000_0000,
		PH_RS_CLKH   = 20'b0000_0001_0000_0000_0000,
		PH_RS_CLKL2  = 20'b0000_0010_0000_0000_0000,
		PH_RX_HIGH   = 20'b0000_0100_0000_0000_0000,
		PH_RX_LOW    = 20'b0000_1000_0000_0000_0000,
		PH_RP_HIGH   = 20'b0001_0000_0000_0000_0000,
		PH_RP_LOW    = 20'b0010_0000_0000_0000_0000,
		PH_STOP_DATA = 20'b0100_0000_0000_0000_0000,
		PH_STOP_CLK  = 20'b1000_0000_0000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [16:0] timeout_ticks;
		logic [9:0]  bit_setup_ticks;
		logic [15:0] inhibit_ticks;
	} cfg_t;

	typedef struct packed {
		logic       clk_pull_low;
		logic       data_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic [1:0] status;
	} result_t;

endpackage
`default_nettype wire

// ===== design/ps2h_host_transceiver.sv =====
// PS/2 host line engine, one request per tick of the line sampling clock while out_stall is low.
// Input channel (in_valid / in_stall): func, cmd_byte and the sampled levels
// of the PS/2 data and clock lines. func 1 sends cmd_byte and receives the
// reply frame, func 2 receives one frame, func 0 only advances the engine.
// Output channel (out_valid / out_stall): one result per request with the line
// drives, busy, done, the received byte and status (ok, timeout, parity).
// Configuration (cfg_valid / cfg_ready, always ready): index 0 timeout ticks,
// 1 bit setup ticks, 2 inhibit ticks; they must be written by the user only
// while the engine is idle; the block itself has no check for it. A request is
// held in the input register, stepped by the engine and offered from the
// result register. Throughput: one request per cycle while out_stall is low;
// the limit is the single engine step between the input and result registers.
// A stalled result is held in the result register; the engine then stops and
// the input register stalls the sender. Request stall follows out_stall
// combinationally only while the input and result registers are both occupied.
// Reset: engine idle, both lines released, registers to their default values,
// input and result registers empty.
`default_nettype none
module ps2_host_transceiver
	import ps2h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  cmd_byte,
	input  wire logic        clk_line,
	input  wire logic        data_line,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             clk_pull_low,
	output logic             data_pull_low,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       rx_byte,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s1, valid_s2;
	logic [1:0] func_s1;
	logic [7:0] cmd_s1;
	logic       clk_line_s1, data_line_s1;
	logic       advance, in_accept;

	assign cfg_ready = 1'b1;

	ps2h_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake between input register, engine and result register
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept)    valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance)        valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1      <= func;
			cmd_s1       <= cmd_byte;
			clk_line_s1  <= clk_line;
			data_line_s1 <= data_line;
		end
	end

	ps2h_line_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.func      (func_s1),
		.cmd_byte  (cmd_s1),
		.clk_line  (clk_line_s1),
		.data_line (data_line_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign clk_pull_low  = res_s2.clk_pull_low;
	assign data_pull_low = res_s2.data_pull_low;
	assign busy_res      = res_s2.busy_res;
	assign done_res      = res_s2.done_res;
	assign rx_byte       = res_s2.rx_byte;
	assign status        = res_s2.status;

endmodule
`default_nettype wire

// ===== design/ps2h_cfg_regs.sv =====
`default_nettype none
module ps2h_cfg_regs
	import ps2h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= TIMEOUT_RESET;
			cfg_q.bit_setup_ticks <= BIT_SETUP_RESET;
			cfg_q.inhibit_ticks   <= INHIBIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_data;
				CFG_BIT_SETUP: cfg_q.bit_setup_ticks <= cfg_data[9:0];
				CFG_INHIBIT:   cfg_q.inhibit_ticks   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== design/ps2h_line_engine.sv =====
`default_nettype none
module ps2h_line_engine
	import ps2h_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [1:0] func,
	input  wire logic [7:0] cmd_byte,
	input  wire logic       clk_line,
	input  wire logic       data_line,
	input  wire cfg_t       cfg,
	output result_t         res
);

	phase_t      phase_q, phase_n;
	logic [3:0]  bit_count_q, bit_count_n;
	logic [7:0]  shift_q, shift_n;
	logic        parity_q, parity_n;
	logic [16:0] wait_q, wait_n;
	logic [15:0] delay_q, delay_n;
	logic        with_cmd_q, with_cmd_n;
	logic [1:0]  drive_q, drive_n;

	logic        wait_act, met, timed_out, done;
	status_t     status;
	logic [7:0]  rxb;
	logic [16:0] wait_inc;
	logic [15:0] delay_inc;
	logic [3:0]  bit_inc;
	logic        parity_upd, next_bit;

	// one tick of the line engine
	always_comb begin
		phase_n     = phase_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		parity_n    = parity_q;
		wait_n      = wait_q;
		delay_n     = delay_q;
		with_cmd_n  = with_cmd_q;
		drive_n     = drive_q;
		wait_act    = 1'b0;
		met         = 1'b0;
		timed_out   = 1'b0;
		done        = 1'b0;
		status      = ST_OK;
		rxb         = 8'd0;
		wait_inc    = wait_q + 17'd1;
		delay_inc   = delay_q + 16'd1;
		bit_inc     = bit_count_q + 4'd1;
		parity_upd  = bit_count_q[3] ? parity_q : (parity_q ^ shift_q[bit_count_q[2:0]]);
		next_bit    = bit_inc[3] ? parity_upd : shift_q[bit_inc[2:0]];

		case (phase_q)
			PH_IDLE: begin
				if (func == FUNC_CMD) begin
					with_cmd_n = 1'b1;
					shift_n    = cmd_byte;
					wait_n     = 17'd0;
					delay_n    = 16'd0;
					drive_n    = 2'b01;
					phase_n    = PH_INHIBIT;
				end else if (func == FUNC_READ) begin
					with_cmd_n  = 1'b0;
					shift_n     = 8'd0;
					bit_count_n = 4'd0;
					parity_n    = 1'b1;
					wait_n      = 17'd0;
					phase_n     = PH_RS_DATA;
				end
			end
			PH_INHIBIT: begin
				delay_n = delay_inc;
				if (delay_inc >= cfg.inhibit_ticks) begin
					drive_n = 2'b10;
					wait_n  = 17'd0;
					phase_n = PH_TX_REQ;
				end
			end
			PH_TX_REQ: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) begin
					bit_count_n = 4'd0;
					parity_n    = 1'b1;
					drive_n[1]  = !shift_q[0];
					delay_n     = 16'd0;
					phase_n     = PH_TX_SETUP;
				end
			end
			PH_TX_SETUP: begin
				delay_n = delay_inc;
				if (delay_inc >= {6'd0, cfg.bit_setup_ticks}) begin
					wait_n  = 17'd0;
					phase_n = PH_TX_HIGH;
				end
			end
			PH_TX_HIGH: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) phase_n = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) begin
					parity_n    = parity_upd;
					bit_count_n = bit_inc;
					if (bit_inc <= 4'd8) begin
						drive_n[1] = !next_bit;
						delay_n    = 16'd0;
						phase_n    = PH_TX_SETUP;
					end else begin
						drive_n[1] = 1'b0;
						phase_n    = PH_ACK_DATA;
					end
				end
			end
			PH_ACK_DATA: begin
				wait_act = 1'b1;
				met      = !data_line;
				if (met) phase_n = PH_ACK_CLK;
			end
			PH_ACK_CLK: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) phase_n = PH_REL_DATA;
			end
			PH_REL_DATA: begin
				wait_act = 1'b1;
				met      = data_line;
				if (met) phase_n = PH_REL_CLK;
			end
			PH_REL_CLK: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) begin
					shift_n     = 8'd0;
					bit_count_n = 4'd0;
					parity_n    = 1'b1;
					phase_n     = PH_RS_DATA;
				end
			end
			PH_RS_DATA: begin
				wait_act = 1'b1;
				met      = !data_line;
				if (met) phase_n = PH_RS_CLKL;
			end
			PH_RS_CLKL: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) phase_n = PH_RS_CLKH;
			end
			PH_RS_CLKH: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) phase_n = PH_RS_CLKL2;
			end
			PH_RS_CLKL2: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) phase_n = PH_RX_HIGH;
			end
			PH_RX_HIGH: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) begin
					if (data_line) begin
						shift_n[bit_count_q[2:0]] = 1'b1;
						parity_n = !parity_q;
					end
					phase_n = PH_RX_LOW;
				end
			end
			PH_RX_LOW: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) begin
					bit_count_n = bit_inc;
					phase_n     = (bit_inc >= 4'd8) ? PH_RP_HIGH : PH_RX_HIGH;
				end
			end
			PH_RP_HIGH: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) begin
					if (data_line != parity_q) begin
						done   = 1'b1;
						status = ST_PARITY;
					end else begin
						phase_n = PH_RP_LOW;
					end
				end
			end
			PH_RP_LOW: begin
				wait_act = 1'b1;
				met      = !clk_line;
				if (met) phase_n = PH_STOP_DATA;
			end
			PH_STOP_DATA: begin
				wait_act = 1'b1;
				met      = data_line;
				if (met) phase_n = PH_STOP_CLK;
			end
			PH_STOP_CLK: begin
				wait_act = 1'b1;
				met      = clk_line;
				if (met) begin
					done   = 1'b1;
					status = ST_OK;
					rxb    = shift_q;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				drive_n = 2'b00;
			end
		endcase

		// shared wait counter and timeout check
		if (wait_act) begin
			if (met) begin
				wait_n = 17'd0;
			end else begin
				wait_n = wait_inc;
				if (wait_inc >= cfg.timeout_ticks) timed_out = 1'b1;
			end
		end

		if (timed_out) begin
			done   = 1'b1;
			status = ST_TIMEOUT;
		end

		// end of transfer, release everything
		if (done) begin
			phase_n    = PH_IDLE;
			drive_n    = 2'b00;
			wait_n     = 17'd0;
			delay_n    = 16'd0;
			with_cmd_n = 1'b0;
		end
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= 4'd0;
			shift_q     <= 8'd0;
			parity_q    <= 1'b1;
			wait_q      <= 17'd0;
			delay_q     <= 16'd0;
			with_cmd_q  <= 1'b0;
			drive_q     <= 2'b00;
		end else if (step_en) begin
			phase_q     <= phase_n;
			bit_count_q <= bit_count_n;
			shift_q     <= shift_n;
			parity_q    <= parity_n;
			wait_q      <= wait_n;
			delay_q     <= delay_n;
			with_cmd_q  <= with_cmd_n;
			drive_q     <= drive_n;
		end
	end

	// result of this tick
	always_comb begin
		res.clk_pull_low  = drive_n[0];
		res.data_pull_low = drive_n[1];
		res.busy_res      = (phase_n != PH_IDLE) || (with_cmd_n && 1'b0);
		res.done_res      = done;
		res.rx_byte       = rxb;
		res.status        = status;
	end

endmodule
`default_nettype wire
